@@ rtl/ors_pkg.sv @@
package ors_pkg;

  localparam int CODE_BITS_DEFAULT = 64;

  // fixed field widths of the channel payloads
  localparam int OP_W     = 2;
  localparam int CODE_W   = 64;
  localparam int BRANCH_W = 8;
  localparam int POS_W    = 6;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_BITS  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_FAILED  = 2'd1,
    ST_NODEV   = 2'd2
  } status_t;

  typedef struct packed {
    logic              direction_bit;
    logic [POS_W-1:0]  position;
    logic              pass_done;
    logic [CODE_W-1:0] found_code;
    status_t           status;
  } result_t;

endpackage

@@ rtl/ors_if.sv @@
interface ors_cmd_if;
  import ors_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [CODE_W-1:0]          seed_code;
  logic signed [BRANCH_W-1:0] seed_branch;
  logic                       id_bit;
  logic                       complement_bit;

  modport source (
    output valid, operation, seed_code, seed_branch, id_bit, complement_bit,
    input  ready
  );
  modport sink (
    input  valid, operation, seed_code, seed_branch, id_bit, complement_bit,
    output ready
  );
endinterface

interface ors_rsp_if;
  import ors_pkg::*;

  logic              valid;
  logic              ready;
  logic              direction_bit;
  logic [POS_W-1:0]  position;
  logic              pass_done;
  logic [CODE_W-1:0] found_code;
  status_t           status;

  modport source (
    output valid, direction_bit, position, pass_done, found_code, status,
    input  ready
  );
  modport sink (
    input  valid, direction_bit, position, pass_done, found_code, status,
    output ready
  );
endinterface

@@ rtl/ors_step.sv @@
module ors_step #(
  parameter int   CODE_BITS = ors_pkg::CODE_BITS_DEFAULT,
  localparam int  IDX_W     = $clog2(CODE_BITS),
  localparam int  BR_W      = $clog2(CODE_BITS + 1) + 1
) (
  input  logic [ors_pkg::OP_W-1:0]            operation,
  input  logic [ors_pkg::CODE_W-1:0]          seed_code,
  input  logic signed [ors_pkg::BRANCH_W-1:0] seed_branch,
  input  logic                                id_bit,
  input  logic                                complement_bit,
  input  logic [CODE_BITS-1:0]                last_code,
  input  logic signed [BR_W-1:0]              last_branch,
  input  logic signed [BR_W-1:0]              pass_branch,
  input  logic [IDX_W-1:0]                    bit_position,
  input  ors_pkg::status_t                    search_status,
  output logic [CODE_BITS-1:0]                last_code_next,
  output logic signed [BR_W-1:0]              last_branch_next,
  output logic signed [BR_W-1:0]              pass_branch_next,
  output logic [IDX_W-1:0]                    bit_position_next,
  output ors_pkg::status_t                    search_status_next,
  output ors_pkg::result_t                    result
);
  import ors_pkg::*;

  logic signed [BR_W-1:0]     pos_s;
  logic signed [BR_W-1:0]     pb;
  logic signed [BRANCH_W-1:0] sb;
  logic                       stored;
  logic                       dir;
  logic                       fail;
  logic                       clr_branch;
  logic                       last_pos;

  // direction choice for the current position
  always_comb begin
    pos_s      = $signed(BR_W'(bit_position));
    stored     = last_code[bit_position];
    dir        = 1'b0;
    fail       = 1'b0;
    clr_branch = 1'b0;
    if (pos_s < last_branch) begin
      dir = stored;
      if (stored) begin
        fail = complement_bit;
      end else if (id_bit) begin
        if (complement_bit) begin
          fail = 1'b1;
        end else begin
          dir        = 1'b1;
          clr_branch = 1'b1;
        end
      end
    end else if (pos_s == last_branch) begin
      fail = complement_bit;
      dir  = 1'b1;
    end else begin
      fail = id_bit && complement_bit;
      dir  = id_bit;
    end
    last_pos = (bit_position == IDX_W'(CODE_BITS - 1));
    pb = (!dir && !complement_bit) ? pos_s : pass_branch;
  end

  always_comb begin
    last_code_next     = last_code;
    last_branch_next   = last_branch;
    pass_branch_next   = pass_branch;
    bit_position_next  = bit_position;
    search_status_next = search_status;
    result             = '0;
    result.position    = POS_W'(bit_position);
    result.status      = search_status;
    sb                 = seed_branch;

    unique case (operation)
      OP_LOAD: begin
        if (sb < -8'sd1) begin
          sb = -8'sd1;
        end else if (sb > $signed(8'(CODE_BITS))) begin
          sb = $signed(8'(CODE_BITS));
        end
        last_code_next     = seed_code[CODE_BITS-1:0];
        last_branch_next   = BR_W'(sb);
        pass_branch_next   = '1;
        bit_position_next  = '0;
        search_status_next = ST_SUCCESS;
        result.position    = '0;
        result.status      = ST_SUCCESS;
      end
      OP_BEGIN: begin
        bit_position_next = '0;
        pass_branch_next  = '1;
        result.position   = '0;
      end
      OP_BITS: begin
        if (search_status == ST_SUCCESS) begin
          if (fail) begin
            search_status_next = ST_FAILED;
            result.status      = ST_FAILED;
          end else begin
            last_code_next[bit_position] = dir;
            if (clr_branch) begin
              last_branch_next = '1;
            end
            result.direction_bit = dir;
            if (last_pos) begin
              // end of pass: a missing branch point means every device is found
              if (pb[BR_W-1]) begin
                search_status_next = ST_NODEV;
              end else begin
                last_branch_next = pb;
              end
              pass_branch_next  = '1;
              bit_position_next = '0;
              result.pass_done  = 1'b1;
              result.found_code = CODE_W'(last_code_next);
            end else begin
              pass_branch_next  = pb;
              bit_position_next = bit_position + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/one_wire_rom_search_engine.sv @@
// channel   dir   transfer when          payload
// cmd       in    cmd.valid & cmd.ready  operation, seed_code, seed_branch, id_bit, complement_bit
// rsp       out   rsp.valid & rsp.ready  direction_bit, position, pass_done, found_code, status
//
// one item per cycle sustained while rsp is not stalled; each item gives one result, held first
// in the item register and then in the result register; the rate is set by the combinational
// decision step between those two registers, which also updates the search state
// synchronous active-high reset restores the fresh-enumeration state: code zero, no
// branch point, position zero, status success
// a stalled rsp holds the result and the item register; cmd.ready drops only when both are full
module one_wire_rom_search_engine #(
  parameter int CODE_BITS = ors_pkg::CODE_BITS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  ors_cmd_if.sink cmd,
  ors_rsp_if.source rsp
);
  import ors_pkg::*;

  localparam int IDX_W = $clog2(CODE_BITS);
  localparam int BR_W  = $clog2(CODE_BITS + 1) + 1;

  // item register
  logic                       item_valid;
  logic [OP_W-1:0]            item_op;
  logic [CODE_W-1:0]          item_code;
  logic signed [BRANCH_W-1:0] item_branch;
  logic                       item_id;
  logic                       item_comp;

  // search state
  logic [CODE_BITS-1:0]   last_code;
  logic signed [BR_W-1:0] last_branch;
  logic signed [BR_W-1:0] pass_branch;
  logic [IDX_W-1:0]       bit_position;
  status_t                search_status;

  logic [CODE_BITS-1:0]   last_code_next;
  logic signed [BR_W-1:0] last_branch_next;
  logic signed [BR_W-1:0] pass_branch_next;
  logic [IDX_W-1:0]       bit_position_next;
  status_t                search_status_next;
  result_t                step_res;

  // result register
  logic    res_valid;
  result_t res;

  logic advance;

  // the item moves on when the result register is empty or being drained
  assign advance   = item_valid && (!res_valid || rsp.ready);
  assign cmd.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item_op     <= cmd.operation;
      item_code   <= cmd.seed_code;
      item_branch <= cmd.seed_branch;
      item_id     <= cmd.id_bit;
      item_comp   <= cmd.complement_bit;
    end
  end

  ors_step #(
    .CODE_BITS (CODE_BITS)
  ) u_step (
    .operation          (item_op),
    .seed_code          (item_code),
    .seed_branch        (item_branch),
    .id_bit             (item_id),
    .complement_bit     (item_comp),
    .last_code          (last_code),
    .last_branch        (last_branch),
    .pass_branch        (pass_branch),
    .bit_position       (bit_position),
    .search_status      (search_status),
    .last_code_next     (last_code_next),
    .last_branch_next   (last_branch_next),
    .pass_branch_next   (pass_branch_next),
    .bit_position_next  (bit_position_next),
    .search_status_next (search_status_next),
    .result             (step_res)
  );

  // state commits only as the item hands its result over
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code     <= '0;
      last_branch   <= '1;
      pass_branch   <= '1;
      bit_position  <= '0;
      search_status <= ST_SUCCESS;
    end else if (advance) begin
      last_code     <= last_code_next;
      last_branch   <= last_branch_next;
      pass_branch   <= pass_branch_next;
      bit_position  <= bit_position_next;
      search_status <= search_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.direction_bit = res.direction_bit;
  assign rsp.position      = res.position;
  assign rsp.pass_done     = res.pass_done;
  assign rsp.found_code    = res.found_code;
  assign rsp.status        = res.status;

endmodule

@@ rtl/ors_check.sv @@
module ors_check #(
  parameter int CODE_BITS = ors_pkg::CODE_BITS_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_direction_bit,
  input logic [ors_pkg::POS_W-1:0]   rsp_position,
  input logic                        rsp_pass_done,
  input logic [ors_pkg::CODE_W-1:0]  rsp_found_code,
  input ors_pkg::status_t            rsp_status
);
  import ors_pkg::*;

  // a finished pass always refers to the last bit position
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_pass_done |-> rsp_position == POS_W'(CODE_BITS - 1))
    else $error("pass_done away from the last position");

  // a finished pass reports success
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_pass_done |-> rsp_status == ST_SUCCESS)
    else $error("pass_done with a failure status");

  // a failure writes no bit and completes nothing
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FAILED |-> !rsp_direction_bit && !rsp_pass_done)
    else $error("failure result carries a direction or pass_done");

  // the code shows only with a finished pass
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_pass_done |-> rsp_found_code == '0)
    else $error("found_code without pass_done");

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

endmodule

bind one_wire_rom_search_engine ors_check #(
  .CODE_BITS (CODE_BITS)
) u_ors_check (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_direction_bit (rsp.direction_bit),
  .rsp_position      (rsp.position),
  .rsp_pass_done     (rsp.pass_done),
  .rsp_found_code    (rsp.found_code),
  .rsp_status        (rsp.status)
);

@@ tb/ors_tb_pkg.sv @@
package ors_tb_pkg;
  import ors_pkg::*;

  localparam int SEARCH_BITS = CODE_BITS_DEFAULT;

  // operation code that the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic [CODE_W-1:0]          seed_code;
    logic signed [BRANCH_W-1:0] seed_branch;
    logic                       id_bit;
    logic                       complement_bit;
  } search_cmd_t;

  class rom_search_board;
    logic [CODE_W-1:0] code_reg;
    int                branch_at;
    int                pass_fork;
    int                bit_pos;
    status_t           cur_status;
    result_t           awaiting[$];
    int                errors;

    function new();
      code_reg   = '0;
      branch_at  = -1;
      pass_fork  = -1;
      bit_pos    = 0;
      cur_status = ST_SUCCESS;
      errors     = 0;
    endfunction

    // walk one accepted command through the search state, queue its outcome
    function result_t note_item(search_cmd_t c);
      result_t           r;
      int                br;
      logic              not0;
      logic              not1;
      logic              dir;
      logic              fail;
      logic [CODE_W-1:0] mask;
      mask = {CODE_W{1'b1}} >> (CODE_W - SEARCH_BITS);
      r = '0;
      r.status = cur_status;
      not0 = c.id_bit;
      not1 = c.complement_bit;
      dir  = 1'b0;
      fail = 1'b0;
      if (c.operation == OP_LOAD) begin
        br = $signed(c.seed_branch);
        if (br < -1) br = -1;
        if (br > SEARCH_BITS) br = SEARCH_BITS;
        code_reg   = c.seed_code & mask;
        branch_at  = br;
        pass_fork  = -1;
        bit_pos    = 0;
        cur_status = ST_SUCCESS;
        r.status   = ST_SUCCESS;
      end else if (c.operation == OP_BEGIN) begin
        bit_pos   = 0;
        pass_fork = -1;
      end else if (c.operation != OP_BITS || cur_status != ST_SUCCESS) begin
        r.position = bit_pos[POS_W-1:0];
      end else begin
        r.position = bit_pos[POS_W-1:0];
        if (bit_pos < branch_at) begin
          dir = code_reg[bit_pos];
          if (dir) begin
            fail = not1;
          end else if (not0) begin
            if (not1) begin
              fail = 1'b1;
            end else begin
              dir       = 1'b1;
              branch_at = -1;
            end
          end
        end else if (bit_pos == branch_at) begin
          fail = not1;
          dir  = 1'b1;
        end else begin
          fail = not0 && not1;
          dir  = not0;
        end
        if (fail) begin
          cur_status = ST_FAILED;
          r.status   = ST_FAILED;
        end else begin
          if (!dir && !not1) pass_fork = bit_pos;
          code_reg[bit_pos] = dir;
          r.direction_bit = dir;
          if (bit_pos == SEARCH_BITS - 1) begin
            if (pass_fork < 0) cur_status = ST_NODEV;
            else branch_at = pass_fork;
            pass_fork    = -1;
            bit_pos      = 0;
            r.pass_done  = 1'b1;
            r.found_code = code_reg & mask;
            r.status     = ST_SUCCESS;
          end else begin
            bit_pos++;
          end
        end
      end
      awaiting.push_back(r);
      return r;
    endfunction

    function int field_diff(string name, logic [63:0] want, logic [63:0] got, realtime at);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", at, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(result_t got, realtime at);
      result_t want;
      if (awaiting.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", at, got);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      errors += field_diff("direction_bit", want.direction_bit, got.direction_bit, at);
      errors += field_diff("position", want.position, got.position, at);
      errors += field_diff("pass_done", want.pass_done, got.pass_done, at);
      errors += field_diff("found_code", want.found_code, got.found_code, at);
      errors += field_diff("status", want.status, got.status, at);
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ors_pkg::*;
  import ors_tb_pkg::*;

  // long receiver hold-off and the no-transfer watchdog limit
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 540;

  logic clk = 1'b0;
  logic rst;

  ors_cmd_if cmd_if ();
  ors_rsp_if rsp_if ();

  one_wire_rom_search_engine #(
    .CODE_BITS(SEARCH_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  rom_search_board   sb;
  result_t           rsp_got;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_req_cnt  = 0;
  int                hold_ack_cnt  = 0;
  int                hold_left     = 0;
  int                stall_cycles  = 0;
  int                items_done    = 0;
  int                item_target   = 0;
  logic [CODE_W-1:0] dev_codes [16];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // receiver: random back-pressure, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      rsp_got.direction_bit = rsp_if.direction_bit;
      rsp_got.position      = rsp_if.position;
      rsp_got.pass_done     = rsp_if.pass_done;
      rsp_got.found_code    = rsp_if.found_code;
      rsp_got.status        = rsp_if.status;
      sb.check_result(rsp_got, $realtime);
    end
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: any stretch with no transfer on either side that runs too long
  always @(posedge clk) begin
    if (!rst && ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic search_cmd_t make_cmd(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                           logic [BRANCH_W-1:0] branch, logic id,
                                           logic comp);
    search_cmd_t c;
    c.operation      = op;
    c.seed_code      = code;
    c.seed_branch    = branch;
    c.id_bit         = id;
    c.complement_bit = comp;
    return c;
  endfunction

  // offer one command, wait for its transfer, then note it with the scoreboard
  task automatic send_cmd(input search_cmd_t c, output result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.operation      <= c.operation;
    cmd_if.seed_code      <= c.seed_code;
    cmd_if.seed_branch    <= c.seed_branch;
    cmd_if.id_bit         <= c.id_bit;
    cmd_if.complement_bit <= c.complement_bit;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    r = sb.note_item(c);
    items_done++;
  endtask

  task automatic send(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                      input logic [BRANCH_W-1:0] branch, input logic id, input logic comp);
    result_t r;
    send_cmd(make_cmd(op, code, branch, id, comp), r);
  endtask

  // sender pause: nothing offered until every outstanding result is back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaiting.size() != 0) @(posedge clk);
  endtask

  // fully random commands, unused code included
  task automatic send_noise();
    int len;
    int k;
    len = $urandom_range(3, 12);
    for (k = 0; k < len; k++)
      send(2'($urandom_range(3)), {$urandom, $urandom}, 8'($urandom),
           1'($urandom), 1'($urandom));
  endtask

  // full enumeration of a random device population, bus read bits emulated from
  // the devices still matching the direction bits written so far
  task automatic run_enumeration();
    logic [CODE_W-1:0] base;
    logic [15:0]       alive;
    logic              has0;
    logic              has1;
    logic              id;
    logic              comp;
    logic              stop;
    result_t           r;
    int                n;
    int                i;
    int                p;
    int                passes;
    r = '0;
    n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
    base = {$urandom, $urandom};
    for (i = 0; i < n; i++) begin
      // shared prefixes give branch points deep in the tree
      if ($urandom_range(2) == 0) begin
        dev_codes[i] = {$urandom, $urandom};
      end else begin
        dev_codes[i] = base ^ (64'd1 << $urandom_range(63));
        if ($urandom_range(1) == 1) dev_codes[i] = dev_codes[i] ^ (64'd1 << $urandom_range(63));
      end
    end
    // fresh enumeration: any negative branch point saturates to none
    send(OP_LOAD, {$urandom, $urandom},
         ($urandom_range(3) == 0) ? 8'($urandom_range(128, 255)) : 8'hff, 1'($urandom),
         1'($urandom));
    passes = 0;
    stop   = 1'b0;
    while (!stop && passes < n + 3 && items_done < item_target) begin
      // now and then the next pass starts straight after the last bit
      if ($urandom_range(9) != 0) send(OP_BEGIN, {$urandom, $urandom}, 8'($urandom), 1'b0, 1'b0);
      alive = (16'd1 << n) - 16'd1;
      for (p = 0; p < SEARCH_BITS && !stop && items_done < item_target; p++) begin
        has0 = 1'b0;
        has1 = 1'b0;
        for (i = 0; i < n; i++) begin
          if (alive[i]) begin
            if (dev_codes[i][p]) has1 = 1'b1;
            else has0 = 1'b1;
          end
        end
        id   = !has0;
        comp = !has1;
        // occasional read errors on the bus
        if ($urandom_range(299) == 0) id = ~id;
        if ($urandom_range(299) == 0) comp = ~comp;
        if ($urandom_range(199) == 0)
          send(OP_UNUSED, {$urandom, $urandom}, 8'($urandom), 1'($urandom), 1'($urandom));
        send_cmd(make_cmd(OP_BITS, {$urandom, $urandom}, 8'($urandom), id, comp), r);
        if (r.status != ST_SUCCESS) begin
          stop = 1'b1;
        end else begin
          for (i = 0; i < n; i++)
            if (alive[i] && dev_codes[i][p] != r.direction_bit) alive[i] = 1'b0;
        end
      end
      passes++;
      if (sb.cur_status != ST_SUCCESS) begin
        stop = 1'b1;
      end else if (r.pass_done && $urandom_range(5) == 0) begin
        // resume from the found code, at the current or at some other branch point
        send(OP_LOAD, r.found_code,
             ($urandom_range(2) == 0) ? 8'($urandom_range(0, 64)) : 8'(sb.branch_at),
             1'b0, 1'b0);
      end
    end
    // bit pairs against a sticky status
    repeat ($urandom_range(2))
      send(OP_BITS, {$urandom, $urandom}, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    int phase;
    sb = new();
    rst                   = 1'b1;
    cmd_if.valid          = 1'b0;
    cmd_if.operation      = OP_LOAD;
    cmd_if.seed_code      = '0;
    cmd_if.seed_branch    = '0;
    cmd_if.id_bit         = 1'b0;
    cmd_if.complement_bit = 1'b0;
    rsp_if.ready          = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct <= 54;

    // straight out of reset: no branch point, so the id bit is taken
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b1, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b1);
    send(OP_UNUSED, '1, '1, 1'b1, 1'b1);
    // no device answers at all
    send(OP_BITS, '0, '0, 1'b1, 1'b1);
    // sticky failure: bit pair, unused code and begin all report it
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    send(OP_UNUSED, '0, '0, 1'b0, 1'b0);
    send(OP_BEGIN, '0, '0, 1'b0, 1'b0);
    // branch point above the top saturates, stored ones are followed
    send(OP_LOAD, '1, 8'sd127, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b1);
    // most negative branch point saturates to none
    send(OP_LOAD, '0, 8'sh80, 1'b1, 1'b1);
    send(OP_BITS, '0, '0, 1'b1, 1'b1);
    // stored zero where no device has zero: forced to one, branch point dropped
    send(OP_LOAD, '0, 8'sd2, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b1, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    // at the branch point with no device having one
    send(OP_LOAD, '0, 8'sd1, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b1);
    // stored zero with nothing on the bus
    send(OP_LOAD, {32{2'b10}}, 8'sd2, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b1, 1'b1);
    // branch point at position zero takes one
    send(OP_LOAD, {32{2'b01}}, 8'sd0, 1'b0, 1'b0);
    send(OP_BITS, '0, '0, 1'b0, 1'b0);
    send(OP_LOAD, {$urandom, $urandom}, 8'sd64, 1'b0, 1'b0);
    send(OP_BEGIN, '1, '1, 1'b1, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct <= 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct <= 36;
        end
        default: begin
          // no idling; the receiver holds off for a long stretch while the
          // sender keeps offering, so the block fills and stalls its input
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_req_cnt  <= hold_req_cnt + 1;
        end
      endcase
      item_target = items_done + PHASE_ITEMS;
      while (items_done < item_target) begin
        if ($urandom_range(4) == 0) send_noise();
        else run_enumeration();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
